/* rtl/aarm_pkg.sv */
// Package for the axis-angle rotation matrix block: CORDIC constants,
// arctangent table and shared widths. No dependencies.
package aarm_pkg;

  localparam int AtanEntries = 24;
  localparam int CordicW     = 34;
  localparam logic signed [CordicW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [CordicW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [CordicW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [CordicW-1:0] OneQ30    = 34'sd1073741824;
  localparam logic signed [63:0] EntryMax = 64'sd16384;

  // Return atan(2^-i) at scale 2^30, truncated.
  function automatic logic signed [CordicW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CordicW-1:0] r;
    case (i)
      5'd0:  r = 34'sh3243F6A8;
      5'd1:  r = 34'sh1DAC6705;
      5'd2:  r = 34'sh0FADBAFC;
      5'd3:  r = 34'sh07F56EA6;
      5'd4:  r = 34'sh03FEAB76;
      5'd5:  r = 34'sh01FFD55B;
      5'd6:  r = 34'sh00FFFAAA;
      5'd7:  r = 34'sh007FFF55;
      5'd8:  r = 34'sh003FFFEA;
      5'd9:  r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF;
      5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;
      5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;
      5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;
      5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;
      5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF;
      5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF;
      5'd23: r = 34'sh0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/aarm_cordic.sv */
// Pipelined rotation-mode CORDIC: one register stage per iteration.
// Depends on aarm_pkg. Carries the axis alongside the sine/cosine.
module aarm_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [aarm_pkg::CordicW-1:0] in_x,
  input  logic signed [aarm_pkg::CordicW-1:0] in_z,
  input  logic in_flip,
  input  logic [47:0] in_axis,
  output logic out_valid,
  output logic signed [aarm_pkg::CordicW-1:0] out_sin,
  output logic signed [aarm_pkg::CordicW-1:0] out_cos,
  output logic [47:0] out_axis
);
  import aarm_pkg::*;

  localparam int Run = (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;

  // Stage output registers
  logic signed [CordicW-1:0] x [Run];
  logic signed [CordicW-1:0] y [Run];
  logic signed [CordicW-1:0] z [Run];
  logic flip [Run];
  logic [47:0] axis [Run];
  logic vld [Run];

  // One micro-rotation per stage
  for (genvar i = 0; i < Run; i++) begin : g_stage
    logic signed [CordicW-1:0] xi, yi, zi;
    logic fi, vi;
    logic [47:0] ai;

    // Take the front-end values at the first stage, else the previous stage
    if (i == 0) begin : g_head
      assign xi = in_x;
      assign yi = '0;
      assign zi = in_z;
      assign fi = in_flip;
      assign ai = in_axis;
      assign vi = in_valid;
    end else begin : g_link
      assign xi = x[i-1];
      assign yi = y[i-1];
      assign zi = z[i-1];
      assign fi = flip[i-1];
      assign ai = axis[i-1];
      assign vi = vld[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vi;
      end
      if (en) begin
        flip[i] <= fi;
        axis[i] <= ai;
        if (!zi[CordicW-1]) begin
          x[i] <= xi - (yi >>> i);
          y[i] <= yi + (xi >>> i);
          z[i] <= zi - atan_q30(5'(i));
        end else begin
          x[i] <= xi + (yi >>> i);
          y[i] <= yi - (xi >>> i);
          z[i] <= zi + atan_q30(5'(i));
        end
      end
    end
  end

  assign out_valid = vld[Run-1];
  assign out_cos   = flip[Run-1] ? -x[Run-1] : x[Run-1];
  assign out_sin   = flip[Run-1] ? -y[Run-1] : y[Run-1];
  assign out_axis  = axis[Run-1];
endmodule

/* rtl/axis_angle_rotation_matrix.sv */
// Axis-angle to rotation matrix top level: CORDIC front end, product
// stages and an output register. Depends on aarm_pkg and aarm_cordic.
//
// Takes one transfer per cycle while the output is not stalled and gives one
// matrix per transfer. Stages in order: one fold stage, one CORDIC stage per
// iteration, two multiply stages and the output register, which takes the
// sums already rounded and saturated. A stall freezes the whole pipeline;
// s_tready is high while the output register is empty or being read, so a
// finished result that waits holds the input off.
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [63:0] s_tdata,   // axis_x, axis_y, axis_z, angle
  output logic m_tvalid,
  input  logic m_tready,
  output logic [143:0] m_tdata   // m00 m01 m02 m10 m11 m12 m20 m21 m22
);
  import aarm_pkg::*;

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 0: widen and fold the angle
  logic f_vld, f_flip;
  logic signed [CordicW-1:0] f_z;
  logic [47:0] f_axis;
  logic signed [CordicW-1:0] z_in;
  assign z_in = CordicW'($signed(s_tdata[63:48])) <<< 17;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= s_tvalid;
    end
    if (en) begin
      f_axis <= s_tdata[47:0];
      if (z_in > HalfPiQ30) begin
        f_z <= z_in - PiQ30;
        f_flip <= 1'b1;
      end else if (z_in < -HalfPiQ30) begin
        f_z <= z_in + PiQ30;
        f_flip <= 1'b1;
      end else begin
        f_z <= z_in;
        f_flip <= 1'b0;
      end
    end
  end

  logic c_vld;
  logic signed [CordicW-1:0] c_sin, c_cos;
  logic [47:0] c_axis;

  aarm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst, .en,
    .in_valid(f_vld), .in_x(GainQ30), .in_z(f_z), .in_flip(f_flip),
    .in_axis(f_axis),
    .out_valid(c_vld), .out_sin(c_sin), .out_cos(c_cos), .out_axis(c_axis)
  );

  // Stage A: axis pair products and sine times axis
  logic a_vld;
  logic signed [31:0] pxx, pyy, pzz, pxy, pyz, pzx;
  logic signed [49:0] sx, sy, sz;
  logic signed [CordicW-1:0] a_t, a_cos;
  logic signed [15:0] ax, ay, az;
  assign ax = c_axis[15:0];
  assign ay = c_axis[31:16];
  assign az = c_axis[47:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= c_vld;
    end
    if (en) begin
      pxx <= 32'(ax) * 32'(ax); pyy <= 32'(ay) * 32'(ay); pzz <= 32'(az) * 32'(az);
      pxy <= 32'(ax) * 32'(ay); pyz <= 32'(ay) * 32'(az); pzx <= 32'(az) * 32'(ax);
      sx <= 50'(c_sin) * 50'(ax);
      sy <= 50'(c_sin) * 50'(ay);
      sz <= 50'(c_sin) * 50'(az);
      a_t <= OneQ30 - c_cos;
      a_cos <= c_cos;
    end
  end

  // Stage B: scale pair products by one minus cosine, align the sine and cosine terms
  logic b_vld;
  logic signed [63:0] txx, tyy, tzz, txy, tyz, tzx, bsx, bsy, bsz, bc;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
    if (en) begin
      txx <= 64'(pxx) * 64'(a_t);
      tyy <= 64'(pyy) * 64'(a_t);
      tzz <= 64'(pzz) * 64'(a_t);
      txy <= 64'(pxy) * 64'(a_t);
      tyz <= 64'(pyz) * 64'(a_t);
      tzx <= 64'(pzx) * 64'(a_t);
      bsx <= 64'(sx) <<< 14;
      bsy <= 64'(sy) <<< 14;
      bsz <= 64'(sz) <<< 14;
      bc  <= 64'(a_cos) <<< 28;
    end
  end

  // Round half up to Q1.14 and saturate
  function automatic logic [15:0] finish(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 43)) >>> 44;
    if (r > EntryMax) r = EntryMax;
    if (r < -EntryMax) r = -EntryMax;
    return r[15:0];
  endfunction

  // Stage C: sums into the output register
  logic [143:0] res;
  always_comb begin
    res[15:0]    = finish(txx + bc);
    res[31:16]   = finish(txy - bsz);
    res[47:32]   = finish(tzx + bsy);
    res[63:48]   = finish(txy + bsz);
    res[79:64]   = finish(tyy + bc);
    res[95:80]   = finish(tyz - bsx);
    res[111:96]  = finish(tzx - bsy);
    res[127:112] = finish(tyz + bsx);
    res[143:128] = finish(tzz + bc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= b_vld;
    end
    if (en) begin
      m_tdata <= res;
    end
  end
endmodule

/* tb/sv/axis_angle_rotation_matrix_tb.sv */
// Testbench for axis_angle_rotation_matrix: drives axis/angle transfers, predicts
// each rotation matrix with a local CORDIC and Rodrigues model, checks every entry.
// Depends on the RTL top level only.
`timescale 1ns / 100ps

module axis_angle_rotation_matrix_tb;

  localparam int Stages = 16;
  localparam int Latency = Stages + 4;
  localparam int IdleLimit = 20000;
  localparam int RandomItems = 1550;

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    q14_t angle;
    q14_t az;
    q14_t ay;
    q14_t ax;
  } pose_t;

  typedef struct packed {
    q14_t m22, m21, m20, m12, m11, m10, m02, m01, m00;
  } matrix_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [63:0] s_tdata;   // axis_x, axis_y, axis_z, angle
  logic m_tvalid;
  logic m_tready;
  logic [143:0] m_tdata;  // m00 m01 m02 m10 m11 m12 m20 m21 m22

  int error_count;
  int idle_cycles;
  bit hold_sink;

  axis_angle_rotation_matrix #(.CORDIC_STAGES(Stages)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Arctangent table at scale 2^30
  function automatic longint atan_step(input int i);
    longint tbl[24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return tbl[i];
  endfunction

  // Round half up from scale 2^58 to 2^14, then clamp to +-1.0
  function automatic q14_t round_clamp(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 43)) >>> 44;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return q14_t'(r);
  endfunction

  function automatic matrix_t rotation_of(input pose_t p);
    longint z, x, y, dx, dy, t, c58, sx, sy, sz, ax, ay, az;
    bit flip;
    int n;
    matrix_t m;
    z = longint'(p.angle) * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    n = (Stages > 24) ? 24 : Stages;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    ax = p.ax; ay = p.ay; az = p.az;
    t = 64'sd1073741824 - x;
    c58 = x * (64'sd1 <<< 28);
    sx = y * ax * 16384;
    sy = y * ay * 16384;
    sz = y * az * 16384;
    m.m00 = round_clamp(ax * ax * t + c58);
    m.m01 = round_clamp(ax * ay * t - sz);
    m.m02 = round_clamp(az * ax * t + sy);
    m.m10 = round_clamp(ax * ay * t + sz);
    m.m11 = round_clamp(ay * ay * t + c58);
    m.m12 = round_clamp(ay * az * t - sx);
    m.m20 = round_clamp(az * ax * t - sy);
    m.m21 = round_clamp(ay * az * t + sx);
    m.m22 = round_clamp(az * az * t + c58);
    return m;
  endfunction

  // Holds predicted matrices in transfer order
  class matrix_board;
    matrix_t pending[$];

    function void note_pose(input pose_t p);
      pending = {pending, rotation_of(p)};
    endfunction

    task check_matrix(input matrix_t got);
      matrix_t want;
      if (pending.size() == 0) begin
        report("matrix with no pose outstanding");
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (got[k*16 +: 16] !== want[k*16 +: 16])
          report($sformatf("entry %0d got %0d want %0d", k,
                           $signed(got[k*16 +: 16]), $signed(want[k*16 +: 16])));
      end
    endtask
  endclass

  matrix_board board;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(99) < 80) return 0;
    if ($urandom_range(99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one pose and hold it until the transfer
  task automatic send_pose(input pose_t p);
    s_tvalid <= 1;
    s_tdata <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_pose(p);
  endtask

  task automatic pause_send(input int n);
    s_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  function automatic q14_t rand_comp();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return q14_t'($urandom);
      default: return q14_t'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic q14_t rand_angle();
    case ($urandom_range(7))
      0: return q14_t'($urandom);
      1: return $urandom_range(1) ? 16'sd12868 : -16'sd12868;
      default: return q14_t'($urandom_range(51472) - 25736);
    endcase
  endfunction

  // Sink side: random stalls, plus a forced long hold-off
  initial begin
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_sink) m_tready <= 0;
      else m_tready <= ($urandom_range(99) < 70) || ($urandom_range(9) < 3);
    end
  end

  // Check matrices and watch for a stuck pipeline
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) board.check_matrix(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    pose_t p;
    q14_t edge_angles[8];
    int w;
    board = new();
    error_count = 0;
    hold_sink = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: axis and angle extremes, fold points, zero and non-unit axes
    edge_angles = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767, 16'sh8000,
                    16'sd12868, -16'sd12868, 16'sd12869};
    foreach (edge_angles[i]) send_pose('{edge_angles[i], 16'sd0, 16'sd0, 16'sd16384});
    send_pose('{16'sd6434, 16'sd0, 16'sd16384, 16'sd0});
    send_pose('{-16'sd6434, -16'sd16384, 16'sd0, 16'sd0});
    send_pose('{16'sd8000, 16'sd0, 16'sd0, 16'sd0});
    send_pose('{16'sd20000, 16'sd32767, 16'sd32767, 16'sd32767});
    send_pose('{-16'sd20000, 16'sh8000, 16'sh8000, 16'sh8000});
    send_pose('{16'sd25736, 16'sd16384, -16'sd16384, 16'sd16384});
    send_pose('{16'sd1, 16'sd9459, 16'sd9459, 16'sd9459});
    send_pose('{-16'sd1, -16'sd1, 16'sd1, -16'sd1});
    send_pose('{16'sd12000, 16'sd21845, -16'sd5461, 16'h5555});

    // Drain fully before the random part
    pause_send(0);
    while (board.pending.size() != 0) @(posedge clk);

    // Long receiver hold-off while poses keep coming
    hold_sink = 1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_sink = 0;
      end
      for (int i = 0; i < 60; i++) send_pose('{rand_angle(), rand_comp(), rand_comp(),
                                               rand_comp()});
    join

    for (int i = 0; i < RandomItems; i++) begin
      w = gap_len();
      if (w > 0 && (i / 200) % 2 == 1) pause_send(w);
      p.ax = rand_comp();
      p.ay = rand_comp();
      p.az = rand_comp();
      p.angle = rand_angle();
      send_pose(p);
    end
    s_tvalid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
